@@ hdl/skf_pkg.sv @@
// Shared constants and types for the scalar Kalman filter.
// No dependencies; compiled first.
package skf_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int EST_W   = 32;   // estimate, signed
  localparam int VAR_W   = 48;   // variance, unsigned, 8 fractional bits
  localparam int NOISE_W = 24;   // Q and R registers
  localparam int GAIN_W  = 17;   // gain 0..65536, 16 fractional bits
  localparam int GAIN_FRAC = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 24'd256;
  localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 24'd40192;   // 157.0

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;
  localparam logic [VAR_W-1:0]  VAR_MAX  = {VAR_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCESS_NOISE = 8'd0,
    REG_MEASURE_NOISE = 8'd1
  } cfg_reg_t;

endpackage

@@ hdl/skf_if.sv @@
// Valid/ready channel interfaces for the scalar Kalman filter.
// Depends on skf_pkg.
interface skf_in_if #(
  parameter int SAMPLE_WIDTH = skf_pkg::SAMPLE_WIDTH_DEF
);
  import skf_pkg::*;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface skf_out_if;
  import skf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] estimate;
  logic                    seeded;
  modport source (output valid, output estimate, output seeded, input ready);
  modport sink   (input valid, input estimate, input seeded, output ready);
endinterface

interface skf_cfg_if;
  import skf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [NOISE_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/scalar_kalman_filter_top.sv @@
// Scalar Kalman filter: one filtered Q16.16 estimate per signed sample.
// Depends on skf_pkg and the channel interfaces in skf_if.sv.
//
//   channel  dir  payload                       handshake
//   in_ch    in   sample (SAMPLE_WIDTH, signed)  valid/ready
//   out_ch   out  estimate (32, signed), seeded  valid/ready
//   cfg_ch   in   index (8), data (24)           valid/ready, always ready
//
// A seeding sample goes straight from request to hand-off; every later sample
// runs through these steps from request to result (the division is skipped when R is zero):
// predict, denominator setup, 16 restoring-division steps for the gain,
// 17 shift-add steps for the two products, update, hand-off. The division
// step and the shift-add accumulators are the units reused on every cycle.
// Reset (synchronous, rst_n low) clears estimate and variance and rearms
// seeding. Input is taken only when the sequencer is idle; a result waits
// in the output register, and the sequencer holds its last step until
// that register is free.
module scalar_kalman_filter_top #(
  parameter int SAMPLE_WIDTH = skf_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = skf_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  skf_in_if.sink     in_ch,
  skf_out_if.source  out_ch,
  skf_cfg_if.sink    cfg_ch
);
  import skf_pkg::*;

  localparam int DIFF_W = EST_W + 1;
  localparam int PE_W   = DIFF_W + GAIN_W;   // k * diff, signed
  localparam int PV_W   = VAR_W + GAIN_W - 1; // (1-k) * pm fits 64 bits
  localparam int DEN_W  = VAR_W + 1;
  localparam int REM_W  = VAR_W + 2;
  localparam int CNT_W  = $clog2(GAIN_W + 1);
  localparam int STEP_W = PE_W - GAIN_FRAC;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PRED = 7'b0000010,
    ST_DEN  = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_UPD  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [NOISE_W-1:0]        q_r, r_r;
  logic signed [EST_W-1:0]   est_r;
  logic [VAR_W-1:0]          var_r;
  logic                      first_r;
  logic                      seed_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic [VAR_W-1:0]          pm_r;
  logic [DEN_W-1:0]          den_r;
  logic [REM_W-1:0]          rem_r;
  logic [GAIN_W-1:0]         k_r;
  logic [GAIN_W-1:0]         om_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [PE_W-1:0]    acc_e_r;
  logic [PV_W-1:0]           acc_v_r;
  logic                      out_valid_r;
  logic signed [EST_W-1:0]   out_est_r;
  logic                      out_seed_r;

  logic                      in_req;
  logic signed [63:0]        z_wide;
  logic signed [63:0]        zs_wide;
  logic signed [EST_W-1:0]   zs;
  logic [SAMPLE_WIDTH:0]     z_mag;
  logic [VAR_W:0]            pm_sum;
  logic [REM_W-1:0]          rem_sh;
  logic                      q_bit;
  logic signed [PE_W-1:0]    acc_e_add;
  logic [PV_W-1:0]           acc_v_add;
  logic signed [PE_W-1:0]    prod_rnd;
  logic signed [STEP_W-1:0]  step;
  logic signed [STEP_W:0]    est_sum;
  logic                      out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_req      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.estimate = out_est_r;
  assign out_ch.seeded   = out_seed_r;
  assign out_free        = !out_valid_r || out_ch.ready;

  // sample scaled to the estimate format, clamped to 32-bit signed
  always_comb begin
    z_wide  = 64'(in_ch.sample);
    zs_wide = z_wide <<< FRAC_BITS;
    if (zs_wide > S32_MAX) begin
      zs = EST_W'(S32_MAX);
    end else if (zs_wide < S32_MIN) begin
      zs = EST_W'(S32_MIN);
    end else begin
      zs = EST_W'(zs_wide);
    end
    z_mag = in_ch.sample[SAMPLE_WIDTH-1] ?
            (SAMPLE_WIDTH+1)'(-$signed({in_ch.sample[SAMPLE_WIDTH-1], in_ch.sample})) :
            (SAMPLE_WIDTH+1)'({1'b0, in_ch.sample});
  end

  always_comb begin
    pm_sum    = {1'b0, var_r} + (VAR_W+1)'(q_r);
    rem_sh    = {rem_r[REM_W-2:0], 1'b0};
    q_bit     = (rem_sh >= REM_W'(den_r));
    acc_e_add = k_r[GAIN_W-1] ? PE_W'(diff_r) : '0;
    acc_v_add = om_r[GAIN_W-1] ? PV_W'(pm_r) : '0;
    // round half toward +inf, identical for both signs
    prod_rnd  = acc_e_r + PE_W'(1 << (GAIN_FRAC - 1));
    step      = STEP_W'(prod_rnd >>> GAIN_FRAC);
    est_sum   = (STEP_W+1)'(est_r) + (STEP_W+1)'(step);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_req) state_nxt = first_r ? ST_FIN : ST_PRED;
      end
      ST_PRED: state_nxt = ST_DEN;
      ST_DEN: begin
        state_nxt = (r_r == '0) ? ST_MUL : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(GAIN_FRAC - 1)) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_r == CNT_W'(GAIN_W - 1)) state_nxt = ST_UPD;
      end
      ST_UPD: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      q_r         <= PROCESS_NOISE_RST;
      r_r         <= MEASURE_NOISE_RST;
      est_r       <= '0;
      var_r       <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_PROCESS_NOISE) q_r <= cfg_ch.data;
        else if (cfg_ch.index == REG_MEASURE_NOISE) r_r <= cfg_ch.data;
      end

      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_req) begin
            seed_r <= first_r;
            if (first_r) begin
              first_r <= 1'b0;
              est_r   <= zs;
              var_r   <= VAR_W'(z_mag) << 8;
            end else begin
              diff_r <= DIFF_W'(zs) - DIFF_W'(est_r);
            end
          end
        end
        ST_PRED: begin
          pm_r <= pm_sum[VAR_W] ? VAR_MAX : pm_sum[VAR_W-1:0];
        end
        ST_DEN: begin
          den_r <= DEN_W'(pm_r) + DEN_W'(r_r);
          rem_r <= REM_W'(pm_r);
          cnt_r <= '0;
          // zero R: gain is 1.0, or 0 when the denominator is zero too
          if (r_r == '0) begin
            k_r  <= (pm_r == '0) ? '0 : GAIN_ONE;
            om_r <= (pm_r == '0) ? GAIN_ONE : '0;
          end else begin
            k_r <= '0;
          end
          acc_e_r <= '0;
          acc_v_r <= '0;
        end
        ST_DIV: begin
          rem_r <= q_bit ? rem_sh - REM_W'(den_r) : rem_sh;
          k_r   <= {k_r[GAIN_W-2:0], q_bit};
          om_r  <= GAIN_ONE - {k_r[GAIN_W-2:0], q_bit};
          cnt_r <= (cnt_r == CNT_W'(GAIN_FRAC - 1)) ? '0 : cnt_r + 1'b1;
        end
        ST_MUL: begin
          // MSB-first shift-add for k*diff and (1-k)*pm together
          acc_e_r <= (acc_e_r <<< 1) + acc_e_add;
          acc_v_r <= (acc_v_r << 1) + acc_v_add;
          k_r     <= {k_r[GAIN_W-2:0], 1'b0};
          om_r    <= {om_r[GAIN_W-2:0], 1'b0};
          cnt_r   <= cnt_r + 1'b1;
        end
        ST_UPD: begin
          cnt_r <= '0;
          if (est_sum > (STEP_W+1)'(S32_MAX)) begin
            est_r <= EST_W'(S32_MAX);
          end else if (est_sum < (STEP_W+1)'(S32_MIN)) begin
            est_r <= EST_W'(S32_MIN);
          end else begin
            est_r <= EST_W'(est_sum);
          end
          var_r <= acc_v_r[PV_W-1:GAIN_FRAC];
        end
        ST_FIN: begin
          if (out_free) begin
            out_est_r   <= est_r;
            out_seed_r  <= seed_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
